### hw/rtl/ordered_multi_source_event_queue_macros.svh
// Assertion macros for the ordered multi-source event queue RTL, used by omseq_ctrl.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef ORDERED_MULTI_SOURCE_EVENT_QUEUE_MACROS_SVH
`define ORDERED_MULTI_SOURCE_EVENT_QUEUE_MACROS_SVH

// condition must hold at every edge out of reset
`define OMSEQ_ASSERT_ALW(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define OMSEQ_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OMSEQ_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/omseq_pkg.sv
// Package for the ordered multi-source event queue: sizes, codes and the
// cell command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package omseq_pkg;

	localparam int SOURCES      = 4;
	localparam int DEPTH        = 16;
	localparam int PAYLOAD_BITS = 32;

	localparam int WORD_W = 32;                  // event word port width
	localparam int SRC_W  = 3;                   // source field width
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic [PAYLOAD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		OP_PUSH         = 2'd0,
		OP_POP_GLOBAL   = 2'd1,
		OP_POP_SOURCE   = 2'd2,
		OP_CLEAR_SOURCE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FINISH
	} state_t;

	typedef enum logic [0:0] {
		CFG_ATTACHED_MASK = 1'b0,
		CFG_NOTIFY_ENABLE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		word_t            word;
		logic [SRC_W-1:0] owner;
		logic             linked;
	} slot_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             remove;     // drop first selected slot, shift the tail in
		logic             push;       // write push_data at slot == count
		logic [CNT_W-1:0] count;
		logic             sel_main;   // select on main order instead of owner
		logic [SRC_W-1:0] sel_src;
		logic             chk_main;   // emptiness check on main order
		logic [SRC_W-1:0] chk_src;
		slot_t            push_data;
	} cell_cmd_t;

	// gathered from the row of cells
	typedef struct packed {
		logic             any_hit;
		logic             any_chk;
		word_t            pick_word;
		logic [SRC_W-1:0] pick_owner;
	} chain_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ordered_multi_source_event_queue.sv
// Channel   Direction  Handshake           Payload
// in        to block   in_valid/in_stall   opcode, source, payload
// out       from block out_valid/out_stall got_event, event_word, from_source,
//                                          notify, refused, source_empty
// cfg       to block   cfg_valid/cfg_ready cfg_index, cfg_data
//
// For push and pop the cell row acts on the accept edge; the ST_FINISH state then
// checks emptiness and loads the output register. clear_source drops the first
// match, if any, on the accept edge, then ST_CLEAR shifts out one matching slot
// per cycle until none is left. A stalled output holds the block in its final cycle.
// Reset empties the store through the slot count; no clearing pass.
// Top level: cell row, slot selection gathering and configuration registers.
// Uses omseq_pkg, omseq_cell and omseq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ordered_multi_source_event_queue import omseq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [SRC_W-1:0]   source,
	input  logic [WORD_W-1:0]  payload,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               got_event,
	output logic [WORD_W-1:0]  event_word,
	output logic [SRC_W-1:0]   from_source,
	output logic               notify,
	output logic               refused,
	output logic               source_empty,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [SOURCES-1:0] cfg_data
);

	logic [SOURCES-1:0] attached_mask_q;
	logic               notify_enable_q;
	cell_cmd_t          cmd;
	chain_stat_t        stat;
	slot_t              cell_data [DEPTH];
	logic [DEPTH:0]     seen;
	logic [DEPTH-1:0]   first;
	logic [DEPTH-1:0]   chk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attached_mask_q <= '1;
			notify_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ATTACHED_MASK: attached_mask_q <= cfg_data;
				CFG_NOTIFY_ENABLE: notify_enable_q <= cfg_data[0];
			endcase
		end
	end

	assign seen[0] = 1'b0;

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		slot_t right;
		if (j == DEPTH - 1) begin : g_last
			assign right = cell_data[j];
		end else begin : g_mid
			assign right = cell_data[j+1];
		end
		omseq_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.slot     (IDX_W'(j)),
			.right    (right),
			.seen_in  (seen[j]),
			.seen_out (seen[j+1]),
			.first    (first[j]),
			.chk      (chk[j]),
			.data     (cell_data[j])
		);
	end

	always_comb begin
		stat.any_hit    = seen[DEPTH];
		stat.any_chk    = |chk;
		stat.pick_word  = '0;
		stat.pick_owner = '0;
		// first has at most one bit set, so OR gathers the selected slot
		for (int j = 0; j < DEPTH; j++) begin
			stat.pick_word  = stat.pick_word  | (first[j] ? cell_data[j].word  : '0);
			stat.pick_owner = stat.pick_owner | (first[j] ? cell_data[j].owner : '0);
		end
	end

	omseq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.source        (source),
		.payload       (payload),
		.attached_mask (attached_mask_q),
		.notify_enable (notify_enable_q),
		.stat          (stat),
		.cmd           (cmd),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.got_event     (got_event),
		.event_word    (event_word),
		.from_source   (from_source),
		.notify        (notify),
		.refused       (refused),
		.source_empty  (source_empty)
	);

endmodule

`default_nettype wire

### hw/rtl/omseq_cell.sv
// One slot of the event store: holds word, owner and link, matches locally
// and takes its right neighbor's slot when a removal passes it. Uses omseq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module omseq_cell import omseq_pkg::*; (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [IDX_W-1:0] slot,
	input  slot_t            right,
	input  logic             seen_in,
	output logic             seen_out,
	output logic             first,
	output logic             chk,
	output slot_t            data
);

	slot_t data_q;
	logic  occ;
	logic  is_main;
	logic  hit;
	logic  load;

	assign occ     = CNT_W'(slot) < cmd.count;
	assign is_main = (data_q.owner == '0) || data_q.linked;
	assign hit     = occ && (cmd.sel_main ? is_main : (data_q.owner == cmd.sel_src));
	assign chk     = occ && (cmd.chk_main ? is_main : (data_q.owner == cmd.chk_src));
	assign seen_out = seen_in | hit;
	assign first    = hit & ~seen_in;
	assign load     = cmd.push && (CNT_W'(slot) == cmd.count);
	assign data     = data_q;

	// at or after the removed slot everything moves one place toward the head
	always_ff @(posedge clk) begin
		if (cmd.remove && seen_out) begin
			data_q <= right;
		end else if (load) begin
			data_q <= cmd.push_data;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/omseq_ctrl.sv
// Operation sequencer: decodes transactions, drives the cell row, keeps the
// slot count and the output register. Uses omseq_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_multi_source_event_queue_macros.svh"

module omseq_ctrl import omseq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [SRC_W-1:0]   source,
	input  logic [WORD_W-1:0]  payload,
	input  logic [SOURCES-1:0] attached_mask,
	input  logic               notify_enable,
	input  chain_stat_t        stat,
	output cell_cmd_t          cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               got_event,
	output logic [WORD_W-1:0]  event_word,
	output logic [SRC_W-1:0]   from_source,
	output logic               notify,
	output logic               refused,
	output logic               source_empty
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	opcode_t          op_q;
	logic [SRC_W-1:0] src_q;
	logic [SRC_W-1:0] addr_q;
	logic             got_q;
	word_t            word_q;
	logic [SRC_W-1:0] from_q;
	logic             notify_q;
	logic             refused_q;

	logic              out_valid_q;
	logic              got_event_q;
	logic [WORD_W-1:0] event_word_q;
	logic [SRC_W-1:0]  from_source_q;
	logic              notify_out_q;
	logic              refused_out_q;
	logic              source_empty_q;

	opcode_t          cur_op;
	logic [SRC_W-1:0] cur_src;
	logic             accept;
	logic             is_pop;
	logic             src_ok;
	logic             full;
	logic [SOURCES:0] lk_vec;
	logic             linked;
	logic             push_ok;
	logic             load_out;

	assign cur_op   = (state_q == ST_IDLE) ? opcode_t'(opcode) : op_q;
	assign cur_src  = (state_q == ST_IDLE) ? source : src_q;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign is_pop   = (cur_op == OP_POP_GLOBAL) || (cur_op == OP_POP_SOURCE);
	assign src_ok   = int'(cur_src) <= SOURCES;
	assign full     = (count_q == CNT_W'(DEPTH));
	// bit 0 stands for the main queue, which never links
	assign lk_vec   = {attached_mask, 1'b0} >> cur_src;
	assign linked   = lk_vec[0];
	assign push_ok  = accept && (cur_op == OP_PUSH) && src_ok && !full;
	assign load_out = (state_q == ST_FINISH) && !(out_valid_q && out_stall);

	always_comb begin
		cmd.remove = stat.any_hit &&
			((accept && (is_pop || (cur_op == OP_CLEAR_SOURCE))) || (state_q == ST_CLEAR));
		cmd.push             = push_ok;
		cmd.count            = count_q;
		cmd.sel_main         = (cur_op == OP_POP_GLOBAL) ||
			((cur_op == OP_POP_SOURCE) && (cur_src == '0));
		cmd.sel_src          = cur_src;
		cmd.chk_main         = (addr_q == '0);
		cmd.chk_src          = addr_q;
		cmd.push_data.word   = word_t'(payload);
		cmd.push_data.owner  = cur_src;
		cmd.push_data.linked = linked;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ((cur_op == OP_CLEAR_SOURCE) && stat.any_hit) ?
						ST_CLEAR : ST_FINISH;
				end
			end
			ST_CLEAR: begin
				// one matching slot leaves per cycle
				if (!stat.any_hit) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.remove) begin
				count_q <= count_q - CNT_W'(1);
			end
			out_valid_q <= load_out || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= cur_op;
			src_q     <= cur_src;
			addr_q    <= (cur_op == OP_POP_GLOBAL) ? '0 : cur_src;
			got_q     <= is_pop && stat.any_hit;
			word_q    <= is_pop ? stat.pick_word : '0;
			from_q    <= is_pop ? stat.pick_owner : '0;
			notify_q  <= push_ok && linked && notify_enable;
			refused_q <= (cur_op == OP_PUSH) && src_ok && full;
		end
		if (load_out) begin
			got_event_q    <= got_q;
			event_word_q   <= WORD_W'(word_q);
			from_source_q  <= from_q;
			notify_out_q   <= notify_q;
			refused_out_q  <= refused_q;
			source_empty_q <= !stat.any_chk;
		end
	end

	assign out_valid    = out_valid_q;
	assign got_event    = got_event_q;
	assign event_word   = event_word_q;
	assign from_source  = from_source_q;
	assign notify       = notify_out_q;
	assign refused      = refused_out_q;
	assign source_empty = source_empty_q;

	`OMSEQ_ASSERT_ALW(a_count_bound, count_q <= CNT_W'(DEPTH), "slot count above depth")
	`OMSEQ_ASSERT_IMP(a_remove_nonempty, cmd.remove, count_q != '0, "removal from empty store")
	`OMSEQ_ASSERT_IMP(a_push_room, cmd.push, !cmd.remove && !full, "push into full store")
	`OMSEQ_ASSERT_NXT(a_finish_loads, load_out, out_valid_q && state_q == ST_IDLE, "result lost")
	`OMSEQ_ASSERT_NXT(a_clear_step, state_q == ST_CLEAR && stat.any_hit,
		count_q == $past(count_q) - CNT_W'(1), "clear step did not drop a slot")

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for ordered_multi_source_event_queue: a directed table, then random
// phases over several register settings. Each result is checked against the table's expectation or a shadow store.
// Depends on omseq_pkg and the block RTL only.
`timescale 1ns / 1ps

module testbench;
	import omseq_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic              got_event;
		logic [WORD_W-1:0] event_word;
		logic [SRC_W-1:0]  from_source;
		logic              notify;
		logic              refused;
		logic              source_empty;
	} op_result_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [SRC_W-1:0]  owner;
		bit                linked;
	} shadow_slot_t;

	typedef struct {
		bit                 is_cfg;
		cfg_reg_t           reg_sel;
		logic [SOURCES-1:0] reg_val;
		opcode_t            op;
		logic [SRC_W-1:0]   src;
		logic [WORD_W-1:0]  word;
		int                 reps;
		bit                 typed;
		op_result_t         exp;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic [SRC_W-1:0]   source;
	logic [WORD_W-1:0]  payload;
	logic               out_valid;
	logic               out_stall;
	logic               got_event;
	logic [WORD_W-1:0]  event_word;
	logic [SRC_W-1:0]   from_source;
	logic               notify;
	logic               refused;
	logic               source_empty;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [0:0]         cfg_index;
	logic [SOURCES-1:0] cfg_data;

	shadow_slot_t       shadow_slots[$];
	op_result_t         awaited_outcomes[$];
	stim_row_t          directed_rows[$];
	logic [SOURCES-1:0] shadow_attach;
	bit                 shadow_notify_en;
	int                 mismatches;
	bit                 hold_req;

	ordered_multi_source_event_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.source       (source),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.got_event    (got_event),
		.event_word   (event_word),
		.from_source  (from_source),
		.notify       (notify),
		.refused      (refused),
		.source_empty (source_empty),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("Verification failed");
		$finish;
	end

	// source 0 selects the main order: direct events plus linked child events
	function automatic bit slot_in_queue(int i, logic [SRC_W-1:0] src);
		if (src == 0)
			return shadow_slots[i].owner == 0 || shadow_slots[i].linked;
		return shadow_slots[i].owner == src;
	endfunction

	function automatic op_result_t apply_queue_op(opcode_t op, logic [SRC_W-1:0] src,
			logic [WORD_W-1:0] word);
		op_result_t   r;
		logic [SRC_W-1:0] target;
		shadow_slot_t s;
		int           i;
		r = '0;
		target = src;
		if (op == OP_POP_GLOBAL || op == OP_POP_SOURCE) begin
			if (op == OP_POP_GLOBAL)
				target = 0;
			if (target > SOURCES) begin
				r.source_empty = 1'b1;
				return r;
			end
			for (i = 0; i < shadow_slots.size(); i++) begin
				if (slot_in_queue(i, target)) begin
					r.got_event = 1'b1;
					r.event_word = shadow_slots[i].word;
					r.from_source = shadow_slots[i].owner;
					shadow_slots.delete(i);
					break;
				end
			end
		end else if (src > SOURCES) begin
			r.source_empty = 1'b1;
			return r;
		end else if (op == OP_PUSH) begin
			if (shadow_slots.size() >= DEPTH) begin
				r.refused = 1'b1;
			end else begin
				s.word = word;
				s.owner = src;
				s.linked = src != 0 && shadow_attach[src-1];
				shadow_slots.push_back(s);
				r.notify = s.linked && shadow_notify_en;
			end
		end else begin
			// clear of source 0 drops direct events only, linked children stay
			for (i = shadow_slots.size() - 1; i >= 0; i--)
				if (shadow_slots[i].owner == src)
					shadow_slots.delete(i);
		end
		r.source_empty = 1'b1;
		for (i = 0; i < shadow_slots.size(); i++)
			if (slot_in_queue(i, target))
				r.source_empty = 1'b0;
		return r;
	endfunction

	function automatic op_result_t res(bit got, logic [WORD_W-1:0] word, int owner, bit ntf,
			bit rfs, bit empty);
		op_result_t r;
		r.got_event = got;
		r.event_word = word;
		r.from_source = SRC_W'(owner);
		r.notify = ntf;
		r.refused = rfs;
		r.source_empty = empty;
		return r;
	endfunction

	task automatic add_op(opcode_t op, int src, logic [WORD_W-1:0] word, int reps, bit typed,
			op_result_t exp);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.reg_sel = CFG_ATTACHED_MASK;
		row.reg_val = '0;
		row.op = op;
		row.src = SRC_W'(src);
		row.word = word;
		row.reps = reps;
		row.typed = typed;
		row.exp = exp;
		directed_rows.push_back(row);
	endtask

	task automatic add_cfg(cfg_reg_t sel, logic [SOURCES-1:0] val);
		stim_row_t row;
		row.is_cfg = 1'b1;
		row.reg_sel = sel;
		row.reg_val = val;
		row.op = OP_PUSH;
		row.src = '0;
		row.word = '0;
		row.reps = 0;
		row.typed = 1'b0;
		row.exp = '0;
		directed_rows.push_back(row);
	endtask

	// one transaction; valid is left high so a following item goes back to back
	task automatic send_op(opcode_t op, logic [SRC_W-1:0] src, logic [WORD_W-1:0] word,
			bit typed, op_result_t exp);
		op_result_t r;
		in_valid <= 1'b1;
		opcode <= op;
		source <= src;
		payload <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = apply_queue_op(op, src, word);
		awaited_outcomes.push_back(typed ? exp : r);
	endtask

	task automatic idle_cycles(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t sel, logic [SOURCES-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (sel == CFG_ATTACHED_MASK)
			shadow_attach = val;
		else
			shadow_notify_en = val[0];
	endtask

	task automatic run_phase(int count, int push_pct, bit bursty, int hold_at);
		int               k;
		int               burst_left;
		int               pick;
		opcode_t          op;
		logic [SRC_W-1:0] src;
		logic [WORD_W-1:0] word;
		burst_left = $urandom_range(1, 24);
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < push_pct) begin
				op = OP_PUSH;
			end else begin
				pick = $urandom_range(0, 99);
				op = pick < 35 ? OP_POP_GLOBAL : (pick < 80 ? OP_POP_SOURCE : OP_CLEAR_SOURCE);
			end
			if ($urandom_range(0, 19) == 0)
				src = SRC_W'($urandom_range(SOURCES + 1, 7));
			else
				src = SRC_W'($urandom_range(0, SOURCES));
			case ($urandom_range(0, 7))
				0: word = '0;
				1: word = '1;
				2: word = 32'd1 << $urandom_range(0, 31);
				default: word = $urandom;
			endcase
			if (k == hold_at)
				hold_req = 1'b1;
			send_op(op, src, word, 1'b0, '0);
			if (bursty) begin
				burst_left--;
				if (burst_left == 0) begin
					idle_cycles($urandom_range(1, 8));
					burst_left = $urandom_range(1, 24);
				end
			end
		end
	endtask

	// receiver: stall pattern changes every so often; hold_req forces a long hold-off
	initial begin : receiver
		int mode;
		int left;
		int n;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(16, 200);
				end
				left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= $urandom_range(0, 3) == 0;
					2: out_stall <= $urandom_range(0, 3) != 0;
					default: out_stall <= left % 3 == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		op_result_t act;
		op_result_t exp;
		if (arst_n && out_valid && !out_stall) begin
			act = {got_event, event_word, from_source, notify, refused, source_empty};
			if (awaited_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result transaction at %0t", $realtime);
			end else begin
				exp = awaited_outcomes.pop_front();
				if (act !== exp) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch at %0t", $realtime);
						$display("  expected got=%0b word=%h src=%0d notify=%0b refused=%0b empty=%0b",
							exp.got_event, exp.event_word, exp.from_source, exp.notify,
							exp.refused, exp.source_empty);
						$display("  actual   got=%0b word=%h src=%0d notify=%0b refused=%0b empty=%0b",
							act.got_event, act.event_word, act.from_source, act.notify,
							act.refused, act.source_empty);
					end
				end
			end
		end
	end

	initial begin : stimulus
		int        r;
		int        k;
		stim_row_t row;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_PUSH;
		source <= '0;
		payload <= '0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ATTACHED_MASK;
		cfg_data <= '0;
		mismatches = 0;
		hold_req = 1'b0;
		shadow_attach = '1;
		shadow_notify_en = 1'b1;

		// empty queue, reset register values, out-of-range sources, ignored source on pop_global
		add_op(OP_POP_GLOBAL,   0, '0, 1, 1, res(0, '0, 0, 0, 0, 1));
		add_op(OP_POP_SOURCE,   3, '0, 1, 1, res(0, '0, 0, 0, 0, 1));
		add_op(OP_CLEAR_SOURCE, 2, '0, 1, 1, res(0, '0, 0, 0, 0, 1));
		add_op(OP_PUSH,         0, 32'h0000_0000, 1, 1, res(0, '0, 0, 0, 0, 0));
		add_op(OP_PUSH,         1, 32'hFFFF_FFFF, 1, 1, res(0, '0, 0, 1, 0, 0));
		add_op(OP_PUSH,         4, 32'hA5A5_A5A5, 1, 1, res(0, '0, 0, 1, 0, 0));
		add_op(OP_PUSH,         5, 32'h1234_5678, 1, 1, res(0, '0, 0, 0, 0, 1));
		add_op(OP_PUSH,         7, 32'hFFFF_FFFF, 1, 1, res(0, '0, 0, 0, 0, 1));
		add_op(OP_POP_SOURCE,   6, '0, 1, 1, res(0, '0, 0, 0, 0, 1));
		add_op(OP_CLEAR_SOURCE, 7, '0, 1, 1, res(0, '0, 0, 0, 0, 1));
		add_op(OP_POP_GLOBAL,   7, '0, 1, 1, res(1, 32'h0000_0000, 0, 0, 0, 0));
		add_op(OP_POP_SOURCE,   4, '0, 1, 1, res(1, 32'hA5A5_A5A5, 4, 0, 0, 1));
		add_op(OP_POP_SOURCE,   0, '0, 1, 1, res(1, 32'hFFFF_FFFF, 1, 0, 0, 1));
		// fill the store, then a refused push
		add_op(OP_PUSH,         2, 32'h0000_0100, 8, 0, '0);
		add_op(OP_PUSH,         0, 32'h0000_0200, 8, 0, '0);
		add_op(OP_PUSH,         3, 32'hDEAD_BEEF, 1, 1, res(0, '0, 0, 0, 1, 1));
		// main clear keeps the linked child events
		add_op(OP_CLEAR_SOURCE, 0, '0, 1, 1, res(0, '0, 0, 0, 0, 0));
		add_op(OP_CLEAR_SOURCE, 2, '0, 1, 1, res(0, '0, 0, 0, 0, 1));
		// links are fixed at push time
		add_cfg(CFG_ATTACHED_MASK, 4'b0101);
		add_op(OP_PUSH,         2, 32'd1, 1, 1, res(0, '0, 0, 0, 0, 0));
		add_op(OP_PUSH,         1, 32'd2, 1, 1, res(0, '0, 0, 1, 0, 0));
		add_cfg(CFG_NOTIFY_ENABLE, 4'b0000);
		add_op(OP_PUSH,         3, 32'd3, 1, 1, res(0, '0, 0, 0, 0, 0));
		add_op(OP_POP_GLOBAL,   0, '0, 1, 1, res(1, 32'd2, 1, 0, 0, 0));
		add_op(OP_POP_GLOBAL,   0, '0, 1, 1, res(1, 32'd3, 3, 0, 0, 1));
		add_op(OP_POP_GLOBAL,   0, '0, 1, 1, res(0, '0, 0, 0, 0, 1));
		add_op(OP_POP_SOURCE,   2, '0, 1, 1, res(1, 32'd1, 2, 0, 0, 1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (r = 0; r < directed_rows.size(); r++) begin
			row = directed_rows[r];
			if (row.is_cfg) begin
				drain();
				write_reg(row.reg_sel, row.reg_val);
			end else begin
				for (k = 0; k < row.reps; k++) begin
					send_op(row.op, row.src, row.word + k, row.typed, row.exp);
					idle_cycles($urandom_range(0, 2));
				end
			end
		end

		drain();
		write_reg(CFG_ATTACHED_MASK, 4'b1111);
		write_reg(CFG_NOTIFY_ENABLE, 4'b0001);
		run_phase(150, 55, 1'b0, -1);

		drain();
		write_reg(CFG_ATTACHED_MASK, 4'b0000);
		write_reg(CFG_NOTIFY_ENABLE, 4'b0000);
		run_phase(150, 50, 1'b1, -1);

		// push heavy, with a long receiver hold-off so the input backs up
		drain();
		write_reg(CFG_ATTACHED_MASK, SOURCES'($urandom_range(0, 15)));
		write_reg(CFG_NOTIFY_ENABLE, 4'b0001);
		run_phase(200, 70, 1'b1, 60);

		drain();
		write_reg(CFG_ATTACHED_MASK, 4'b1010);
		write_reg(CFG_NOTIFY_ENABLE, 4'b0001);
		run_phase(150, 35, 1'b1, -1);

		drain();
		write_reg(CFG_ATTACHED_MASK, SOURCES'($urandom_range(0, 15)));
		write_reg(CFG_NOTIFY_ENABLE, SOURCES'($urandom_range(0, 1)));
		run_phase(200, 55, 1'b1, -1);

		drain();
		write_reg(CFG_ATTACHED_MASK, 4'b1111);
		write_reg(CFG_NOTIFY_ENABLE, 4'b0000);
		run_phase(150, 50, 1'b0, -1);

		in_valid <= 1'b0;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0 && awaited_outcomes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
